### rtl/igr_pkg.sv
// ----------------------------------------------------------------------------
// IMU gravity removal: shared package
// Widths, reset values, register map and lane control types.
// ----------------------------------------------------------------------------
package igr_pkg;

    localparam int FRAC_BITS  = 8;
    localparam int NUM_LANES  = 3;
    localparam int SAMPLE_W   = 16;
    localparam int ALPHA_W    = 16;
    localparam int BIAS_W     = 24;
    localparam int ACC_W      = SAMPLE_W + FRAC_BITS;
    localparam int RATE_ACC_W = ACC_W + 1;
    localparam int LIN_W      = 25;
    localparam int RATE_W     = 18;
    localparam int QUOT_W     = 17;
    localparam int PADDR_W    = 5;
    localparam int PDATA_W    = 32;

    localparam int RATE_DIV   = 131;
    localparam int RECIP_SH   = 32;
    localparam logic [RATE_ACC_W-1:0] RATE_RECIP =
        RATE_ACC_W'((64'd1 << RECIP_SH) / 64'(RATE_DIV));

    localparam logic [ALPHA_W-1:0] ACCEL_ALPHA_RST     = 16'd55706;
    localparam logic [ALPHA_W-1:0] GYRO_LP_WEIGHT_RST  = 16'd55706;
    localparam logic [ALPHA_W-1:0] GRAVITY_ALPHA_RST   = 16'd64225;
    localparam logic [ACC_W-1:0]   GRAV_ONE_G          = ACC_W'(16384 << FRAC_BITS);

    typedef enum logic [2:0] {
        REG_ACCEL_ALPHA    = 3'd0,
        REG_GYRO_LP_WEIGHT = 3'd1,
        REG_GRAVITY_ALPHA  = 3'd2,
        REG_GYRO_BIAS_X    = 3'd3,
        REG_GYRO_BIAS_Y    = 3'd4,
        REG_GYRO_BIAS_Z    = 3'd5
    } t_reg_idx;

    typedef enum logic [1:0] {
        STEP_NONE = 2'd0,
        STEP_ACC  = 2'd1,
        STEP_RATE = 2'd2,
        STEP_GRAV = 2'd3
    } t_step;

    typedef struct packed {
        logic  load;
        t_step step;
    } t_lane_ctrl;

endpackage

### rtl/igr_in_if.sv
// ----------------------------------------------------------------------------
// IMU gravity removal: sample channel
// One six-axis raw sample per beat.
// ----------------------------------------------------------------------------
interface igr_in_if;
    logic                 valid;
    logic                 ready;
    logic signed [15:0]   accel_x;
    logic signed [15:0]   accel_y;
    logic signed [15:0]   accel_z;
    logic signed [15:0]   gyro_x;
    logic signed [15:0]   gyro_y;
    logic signed [15:0]   gyro_z;

    modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                    input ready);
    modport sink   (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                    output ready);
endinterface

### rtl/igr_out_if.sv
// ----------------------------------------------------------------------------
// IMU gravity removal: result channel
// Linear acceleration and filtered rate per beat.
// ----------------------------------------------------------------------------
interface igr_out_if;
    logic                 valid;
    logic                 ready;
    logic signed [24:0]   lin_acc_x;
    logic signed [24:0]   lin_acc_y;
    logic signed [24:0]   lin_acc_z;
    logic signed [17:0]   rate_x;
    logic signed [17:0]   rate_y;
    logic signed [17:0]   rate_z;

    modport source (output valid, lin_acc_x, lin_acc_y, lin_acc_z, rate_x, rate_y, rate_z,
                    input ready);
    modport sink   (input valid, lin_acc_x, lin_acc_y, lin_acc_z, rate_x, rate_y, rate_z,
                    output ready);
endinterface

### rtl/imu_gravity_removal_filter.sv
// ----------------------------------------------------------------------------
// IMU gravity removal filter
// Six-axis low-pass filtering, gravity tracking and rate scaling.
// ----------------------------------------------------------------------------
// Each sample steps through the ACC, RATE, GRAV and DONE states: three lanes
// (x, y, z) run side by side, each passing its accel, gyro and gravity low-pass
// filters through one shared multiplier in turn, one filter per cycle, before
// DONE hands the merged result to the output register; a new sample is taken
// in the cycle that result is loaded. Gyro bias, filter weights and rate
// scaling by 1/131 with truncation toward zero are applied per axis; states
// and results carry 8 fraction bits. The user must write registers over
// the APB port only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module imu_gravity_removal_filter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    igr_in_if.sink                            i_sample,
    igr_out_if.source                         o_result,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [igr_pkg::PADDR_W-1:0]       paddr,
    input  logic [igr_pkg::PDATA_W-1:0]       pwdata,
    output logic [igr_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ACC,
        PH_RATE,
        PH_GRAV,
        PH_DONE
    } t_phase;

    t_phase r_phase;
    t_phase n_phase;

    logic [igr_pkg::ALPHA_W-1:0]      r_accel_alpha;
    logic [igr_pkg::ALPHA_W-1:0]      r_gyro_lp_weight;
    logic [igr_pkg::ALPHA_W-1:0]      r_grav_alpha;
    logic signed [igr_pkg::BIAS_W-1:0] r_bias [igr_pkg::NUM_LANES];

    logic                              w_wr;
    igr_pkg::t_reg_idx                 w_idx;
    logic                              w_accept;
    logic                              w_load;
    igr_pkg::t_lane_ctrl               w_ctrl;
    logic signed [igr_pkg::SAMPLE_W-1:0] w_accel [igr_pkg::NUM_LANES];
    logic signed [igr_pkg::SAMPLE_W-1:0] w_gyro  [igr_pkg::NUM_LANES];
    logic        [igr_pkg::ACC_W-1:0]    w_ginit [igr_pkg::NUM_LANES];
    logic signed [igr_pkg::LIN_W-1:0]    w_lin   [igr_pkg::NUM_LANES];
    logic signed [igr_pkg::RATE_W-1:0]   w_rate  [igr_pkg::NUM_LANES];

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = igr_pkg::t_reg_idx'(paddr[igr_pkg::PADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel_alpha    <= igr_pkg::ACCEL_ALPHA_RST;
            r_gyro_lp_weight <= igr_pkg::GYRO_LP_WEIGHT_RST;
            r_grav_alpha     <= igr_pkg::GRAVITY_ALPHA_RST;
            r_bias[0]        <= '0;
            r_bias[1]        <= '0;
            r_bias[2]        <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                igr_pkg::REG_ACCEL_ALPHA:
                    r_accel_alpha <= pwdata[igr_pkg::ALPHA_W-1:0];
                igr_pkg::REG_GYRO_LP_WEIGHT:
                    r_gyro_lp_weight <= pwdata[igr_pkg::ALPHA_W-1:0];
                igr_pkg::REG_GRAVITY_ALPHA:
                    r_grav_alpha <= pwdata[igr_pkg::ALPHA_W-1:0];
                igr_pkg::REG_GYRO_BIAS_X:   r_bias[0] <= pwdata[igr_pkg::BIAS_W-1:0];
                igr_pkg::REG_GYRO_BIAS_Y:   r_bias[1] <= pwdata[igr_pkg::BIAS_W-1:0];
                igr_pkg::REG_GYRO_BIAS_Z:   r_bias[2] <= pwdata[igr_pkg::BIAS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            igr_pkg::REG_ACCEL_ALPHA:    prdata = igr_pkg::PDATA_W'(r_accel_alpha);
            igr_pkg::REG_GYRO_LP_WEIGHT: prdata = igr_pkg::PDATA_W'(r_gyro_lp_weight);
            igr_pkg::REG_GRAVITY_ALPHA:  prdata = igr_pkg::PDATA_W'(r_grav_alpha);
            igr_pkg::REG_GYRO_BIAS_X:    prdata = igr_pkg::PDATA_W'(r_bias[0]);
            igr_pkg::REG_GYRO_BIAS_Y:    prdata = igr_pkg::PDATA_W'(r_bias[1]);
            igr_pkg::REG_GYRO_BIAS_Z:    prdata = igr_pkg::PDATA_W'(r_bias[2]);
            default:                     prdata = '0;
        endcase
    end

    assign i_sample.ready = (r_phase == PH_IDLE) || ((r_phase == PH_DONE) && w_load);
    assign w_accept       = i_sample.valid && i_sample.ready;

    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_IDLE: if (w_accept) n_phase = PH_ACC;
            PH_ACC:  n_phase = PH_RATE;
            PH_RATE: n_phase = PH_GRAV;
            PH_GRAV: n_phase = PH_DONE;
            PH_DONE: begin
                if (w_accept) begin
                    n_phase = PH_ACC;
                end else if (w_load) begin
                    n_phase = PH_IDLE;
                end
            end
            default: n_phase = PH_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_comb begin
        w_ctrl.load = w_accept;
        unique case (r_phase)
            PH_ACC:  w_ctrl.step = igr_pkg::STEP_ACC;
            PH_RATE: w_ctrl.step = igr_pkg::STEP_RATE;
            PH_GRAV: w_ctrl.step = igr_pkg::STEP_GRAV;
            default: w_ctrl.step = igr_pkg::STEP_NONE;
        endcase
    end

    assign w_accel[0] = i_sample.accel_x;
    assign w_accel[1] = i_sample.accel_y;
    assign w_accel[2] = i_sample.accel_z;
    assign w_gyro[0]  = i_sample.gyro_x;
    assign w_gyro[1]  = i_sample.gyro_y;
    assign w_gyro[2]  = i_sample.gyro_z;
    assign w_ginit[0] = '0;
    assign w_ginit[1] = '0;
    assign w_ginit[2] = igr_pkg::GRAV_ONE_G;

    for (genvar g = 0; g < igr_pkg::NUM_LANES; g++) begin : g_lane
        igr_lane u_lane (
            .i_clk            (i_clk),
            .i_rst_n          (i_rst_n),
            .i_ctrl           (w_ctrl),
            .i_accel          (w_accel[g]),
            .i_gyro           (w_gyro[g]),
            .i_bias           (r_bias[g]),
            .i_accel_alpha    (r_accel_alpha),
            .i_gyro_lp_weight (r_gyro_lp_weight),
            .i_grav_alpha     (r_grav_alpha),
            .i_grav_init      (w_ginit[g]),
            .o_lin            (w_lin[g]),
            .o_rate           (w_rate[g])
        );
    end

    igr_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_done   (r_phase == PH_DONE),
        .i_lin    (w_lin),
        .i_rate   (w_rate),
        .o_load   (w_load),
        .o_result (o_result)
    );

endmodule

### rtl/igr_lane.sv
// ----------------------------------------------------------------------------
// IMU gravity removal: axis lane
// Accel, gyro and gravity low-pass filters for one axis on a shared
// multiplier, plus rate scaling by reciprocal multiply and correction.
// ----------------------------------------------------------------------------
module igr_lane (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  igr_pkg::t_lane_ctrl                      i_ctrl,
    input  logic signed [igr_pkg::SAMPLE_W-1:0]      i_accel,
    input  logic signed [igr_pkg::SAMPLE_W-1:0]      i_gyro,
    input  logic signed [igr_pkg::BIAS_W-1:0]        i_bias,
    input  logic        [igr_pkg::ALPHA_W-1:0]       i_accel_alpha,
    input  logic        [igr_pkg::ALPHA_W-1:0]       i_gyro_lp_weight,
    input  logic        [igr_pkg::ALPHA_W-1:0]       i_grav_alpha,
    input  logic        [igr_pkg::ACC_W-1:0]         i_grav_init,
    output logic signed [igr_pkg::LIN_W-1:0]         o_lin,
    output logic signed [igr_pkg::RATE_W-1:0]        o_rate
);

    localparam int DW = igr_pkg::RATE_ACC_W + 1;
    localparam int PW = igr_pkg::ALPHA_W + 1 + DW;
    localparam int MW = igr_pkg::RATE_ACC_W;

    logic signed [igr_pkg::ACC_W-1:0]      r_ax;
    logic signed [igr_pkg::RATE_ACC_W-1:0] r_gx;
    logic signed [igr_pkg::ACC_W-1:0]      r_sa;
    logic signed [igr_pkg::RATE_ACC_W-1:0] r_sr;
    logic signed [igr_pkg::ACC_W-1:0]      r_g;
    logic        [MW-1:0]                  r_mag;
    logic        [igr_pkg::QUOT_W-1:0]     r_q0;
    logic                                  r_neg;

    logic signed [igr_pkg::ALPHA_W:0] w_alpha;
    logic signed [DW-1:0]             w_prev;
    logic signed [DW-1:0]             w_cur;
    logic signed [DW-1:0]             w_diff;
    logic signed [PW-1:0]             w_prod;
    logic        [DW:0]               w_filt;
    logic        [MW-1:0]             w_mag;
    logic        [2*MW-1:0]           w_prod2;
    logic        [MW-1:0]             w_rem;
    logic        [igr_pkg::RATE_W-1:0] w_q;

    always_comb begin
        unique case (i_ctrl.step)
            igr_pkg::STEP_ACC: begin
                w_alpha = {1'b0, i_accel_alpha};
                w_prev  = {{2{r_sa[igr_pkg::ACC_W-1]}}, r_sa};
                w_cur   = {{2{r_ax[igr_pkg::ACC_W-1]}}, r_ax};
            end
            igr_pkg::STEP_RATE: begin
                w_alpha = {1'b0, i_gyro_lp_weight};
                w_prev  = {r_sr[igr_pkg::RATE_ACC_W-1], r_sr};
                w_cur   = {r_gx[igr_pkg::RATE_ACC_W-1], r_gx};
            end
            igr_pkg::STEP_GRAV: begin
                w_alpha = {1'b0, i_grav_alpha};
                w_prev  = {{2{r_g[igr_pkg::ACC_W-1]}}, r_g};
                w_cur   = {{2{r_sa[igr_pkg::ACC_W-1]}}, r_sa};
            end
            default: begin
                w_alpha = '0;
                w_prev  = '0;
                w_cur   = '0;
            end
        endcase
        w_diff = w_prev - w_cur;
        w_prod = w_alpha * w_diff;
        w_filt = {w_cur[DW-1], w_cur} + w_prod[PW-1:16];
    end

    assign w_mag   = r_sr[MW-1] ? MW'(-r_sr) : MW'(r_sr);
    assign w_prod2 = w_mag * igr_pkg::RATE_RECIP;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sa <= '0;
            r_sr <= '0;
            r_g  <= i_grav_init;
        end else begin
            unique case (i_ctrl.step)
                igr_pkg::STEP_ACC:  r_sa <= w_filt[igr_pkg::ACC_W-1:0];
                igr_pkg::STEP_RATE: r_sr <= w_filt[igr_pkg::RATE_ACC_W-1:0];
                igr_pkg::STEP_GRAV: r_g  <= w_filt[igr_pkg::ACC_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_ax <= {i_accel, {igr_pkg::FRAC_BITS{1'b0}}};
            r_gx <= {i_gyro[igr_pkg::SAMPLE_W-1], i_gyro, {igr_pkg::FRAC_BITS{1'b0}}}
                    - {i_bias[igr_pkg::BIAS_W-1], i_bias};
        end
        if (i_ctrl.step == igr_pkg::STEP_GRAV) begin
            r_mag <= w_mag;
            r_neg <= r_sr[MW-1];
            r_q0  <= w_prod2[igr_pkg::RECIP_SH +: igr_pkg::QUOT_W];
        end
    end

    always_comb begin
        w_rem  = r_mag - MW'(MW'(r_q0) * MW'(igr_pkg::RATE_DIV));
        w_q    = igr_pkg::RATE_W'(r_q0)
                 + igr_pkg::RATE_W'(w_rem >= MW'(igr_pkg::RATE_DIV));
        o_rate = r_neg ? igr_pkg::RATE_W'(-w_q) : w_q;
        o_lin  = igr_pkg::LIN_W'({r_sa[igr_pkg::ACC_W-1], r_sa})
                 - igr_pkg::LIN_W'({r_g[igr_pkg::ACC_W-1], r_g});
    end

endmodule

### rtl/igr_merge.sv
// ----------------------------------------------------------------------------
// IMU gravity removal: result merge
// Gathers the three lane results into one output beat and holds it
// in an output register until taken.
// ----------------------------------------------------------------------------
module igr_merge (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_done,
    input  logic signed [igr_pkg::LIN_W-1:0]      i_lin  [igr_pkg::NUM_LANES],
    input  logic signed [igr_pkg::RATE_W-1:0]     i_rate [igr_pkg::NUM_LANES],
    output logic                                  o_load,
    igr_out_if.source                             o_result
);

    logic r_valid;

    assign o_load = i_done && (!r_valid || o_result.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_load) begin
            r_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load) begin
            o_result.lin_acc_x <= i_lin[0];
            o_result.lin_acc_y <= i_lin[1];
            o_result.lin_acc_z <= i_lin[2];
            o_result.rate_x    <= i_rate[0];
            o_result.rate_y    <= i_rate[1];
            o_result.rate_z    <= i_rate[2];
        end
    end

    assign o_result.valid = r_valid;

endmodule

### sim/tb.sv
// ----------------------------------------------------------------------------
// IMU gravity removal filter: testbench
// Streams six-axis samples through the filter under random valid/ready
// gaps, one long output hold-off and several register settings. A shadow
// model of the low-pass, gravity and rate-scaling math predicts every
// output beat, which is checked field by field in arrival order.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_REGS     = 6;
    localparam int HOLD_CYCLES  = 240;
    localparam int DRAIN_CYCLES = 12;
    localparam int RAND_PHASES  = 5;
    localparam int PHASE_ITEMS  = 250;

    typedef struct {
        logic signed [igr_pkg::SAMPLE_W-1:0] accel[3];
        logic signed [igr_pkg::SAMPLE_W-1:0] gyro[3];
    } t_sample;

    typedef struct {
        logic signed [igr_pkg::LIN_W-1:0]  lin[3];
        logic signed [igr_pkg::RATE_W-1:0] rate[3];
    } t_motion;

    typedef logic [igr_pkg::PDATA_W-1:0] t_reg_image [NUM_REGS+2];

    class t_imu_filter_tracker;
        logic [igr_pkg::ALPHA_W-1:0] accel_alpha;
        logic [igr_pkg::ALPHA_W-1:0] gyro_lp_weight;
        logic [igr_pkg::ALPHA_W-1:0] gravity_alpha;
        longint                      gyro_bias[3];
        longint                      accel_lp[3];
        longint                      rate_lp[3];
        longint                      gravity[3];
        t_motion                     pending_motion[$];
        int                          mismatches;

        function new();
            accel_alpha    = igr_pkg::ACCEL_ALPHA_RST;
            gyro_lp_weight = igr_pkg::GYRO_LP_WEIGHT_RST;
            gravity_alpha  = igr_pkg::GRAVITY_ALPHA_RST;
            for (int k = 0; k < 3; k++) begin
                gyro_bias[k] = 0;
                accel_lp[k]  = 0;
                rate_lp[k]   = 0;
                gravity[k]   = 0;
            end
            gravity[2] = longint'(igr_pkg::GRAV_ONE_G);
            mismatches = 0;
        endfunction

        function void write_reg(int idx, logic [igr_pkg::PDATA_W-1:0] data);
            case (idx)
                igr_pkg::REG_ACCEL_ALPHA:
                    accel_alpha = data[igr_pkg::ALPHA_W-1:0];
                igr_pkg::REG_GYRO_LP_WEIGHT:
                    gyro_lp_weight = data[igr_pkg::ALPHA_W-1:0];
                igr_pkg::REG_GRAVITY_ALPHA:
                    gravity_alpha = data[igr_pkg::ALPHA_W-1:0];
                igr_pkg::REG_GYRO_BIAS_X:
                    gyro_bias[0] = longint'(signed'(data[igr_pkg::BIAS_W-1:0]));
                igr_pkg::REG_GYRO_BIAS_Y:
                    gyro_bias[1] = longint'(signed'(data[igr_pkg::BIAS_W-1:0]));
                igr_pkg::REG_GYRO_BIAS_Z:
                    gyro_bias[2] = longint'(signed'(data[igr_pkg::BIAS_W-1:0]));
                default: ;
            endcase
        endfunction

        function longint smooth(longint prev, longint cur, logic [igr_pkg::ALPHA_W-1:0] a);
            longint sum;
            sum = longint'(a) * prev + (longint'(65536) - longint'(a)) * cur;
            return sum >>> 16;
        endfunction

        function void note_sample(t_sample s);
            t_motion m;
            longint  ax;
            longint  gx;
            for (int k = 0; k < 3; k++) begin
                ax = longint'(s.accel[k]) * (longint'(1) << igr_pkg::FRAC_BITS);
                gx = longint'(s.gyro[k]) * (longint'(1) << igr_pkg::FRAC_BITS)
                     - gyro_bias[k];
                accel_lp[k] = smooth(accel_lp[k], ax, accel_alpha);
                rate_lp[k]  = smooth(rate_lp[k], gx, gyro_lp_weight);
                gravity[k]  = smooth(gravity[k], accel_lp[k], gravity_alpha);
                m.lin[k]    = igr_pkg::LIN_W'(accel_lp[k] - gravity[k]);
                m.rate[k]   = igr_pkg::RATE_W'(rate_lp[k] / igr_pkg::RATE_DIV);
            end
            pending_motion.push_back(m);
        endfunction

        function void report(string what, longint want, longint got);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %0d, actual %0d", what, want, got);
        endfunction

        function void check_result(t_motion got);
            t_motion want;
            if (pending_motion.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result beat with no sample pending");
                return;
            end
            want = pending_motion.pop_front();
            for (int k = 0; k < 3; k++) begin
                if (got.lin[k] !== want.lin[k])
                    report($sformatf("lin_acc[%0d]", k), want.lin[k], got.lin[k]);
                if (got.rate[k] !== want.rate[k])
                    report($sformatf("rate[%0d]", k), want.rate[k], got.rate[k]);
            end
        endfunction
    endclass

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [igr_pkg::PADDR_W-1:0] paddr;
    logic [igr_pkg::PDATA_W-1:0] pwdata;
    logic [igr_pkg::PDATA_W-1:0] prdata;
    logic                        pready;

    bit no_idle       = 1'b0;
    int hold_requests = 0;

    t_imu_filter_tracker tracker = new();

    igr_in_if  smp_if ();
    igr_out_if res_if ();

    imu_gravity_removal_filter dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (smp_if),
        .o_result (res_if),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("imu_gravity_removal_filter test failed");
        $finish;
    end

    always @(posedge i_clk) begin : beat_monitor
        t_sample s;
        t_motion r;
        if (i_rst_n) begin
            if (smp_if.valid && smp_if.ready) begin
                s.accel[0] = smp_if.accel_x;
                s.accel[1] = smp_if.accel_y;
                s.accel[2] = smp_if.accel_z;
                s.gyro[0]  = smp_if.gyro_x;
                s.gyro[1]  = smp_if.gyro_y;
                s.gyro[2]  = smp_if.gyro_z;
                tracker.note_sample(s);
            end
            if (res_if.valid && res_if.ready) begin
                r.lin[0]  = res_if.lin_acc_x;
                r.lin[1]  = res_if.lin_acc_y;
                r.lin[2]  = res_if.lin_acc_z;
                r.rate[0] = res_if.rate_x;
                r.rate[1] = res_if.rate_y;
                r.rate[2] = res_if.rate_z;
                tracker.check_result(r);
            end
        end
    end

    initial begin : result_sink
        int stall_left;
        int holds_seen;
        stall_left = 0;
        holds_seen = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (holds_seen != hold_requests) begin
                holds_seen = hold_requests;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= no_idle || ($urandom_range(99) >= 16);
            end
        end
    end

    function automatic t_sample mk(logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                                   logic [15:0] gx, logic [15:0] gy, logic [15:0] gz);
        t_sample s;
        s.accel[0] = ax;
        s.accel[1] = ay;
        s.accel[2] = az;
        s.gyro[0]  = gx;
        s.gyro[1]  = gy;
        s.gyro[2]  = gz;
        return s;
    endfunction

    function automatic logic [15:0] random_axis();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic push_sample(t_sample s);
        int gap;
        if (!no_idle && $urandom_range(99) < 16) begin
            gap = $urandom_range(1, 6);
            smp_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        smp_if.valid   <= 1'b1;
        smp_if.accel_x <= s.accel[0];
        smp_if.accel_y <= s.accel[1];
        smp_if.accel_z <= s.accel[2];
        smp_if.gyro_x  <= s.gyro[0];
        smp_if.gyro_y  <= s.gyro[1];
        smp_if.gyro_z  <= s.gyro[2];
        do @(posedge i_clk); while (!smp_if.ready);
    endtask

    task automatic drain();
        smp_if.valid <= 1'b0;
        while (tracker.pending_motion.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(int idx, logic [igr_pkg::PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= igr_pkg::PADDR_W'(idx * 4);
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        tracker.write_reg(idx, data);
    endtask

    task automatic load_config(t_reg_image img);
        for (int k = 0; k < NUM_REGS + 2; k++)
            write_reg(k, img[k]);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin : stimulus
        t_reg_image   img;
        t_sample      s;
        logic [15:0]  alpha;
        logic [23:0]  bias;
        bit           still;

        i_rst_n        <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        smp_if.valid   <= 1'b0;
        smp_if.accel_x <= '0;
        smp_if.accel_y <= '0;
        smp_if.accel_z <= '0;
        smp_if.gyro_x  <= '0;
        smp_if.gyro_y  <= '0;
        smp_if.gyro_z  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset weights and bias
        push_sample(mk(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        push_sample(mk(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
        push_sample(mk(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
        push_sample(mk(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000));
        push_sample(mk(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF));
        push_sample(mk(16'h5555, 16'h5555, 16'h5555, 16'h5555, 16'h5555, 16'h5555));
        push_sample(mk(16'hAAAA, 16'hAAAA, 16'hAAAA, 16'hAAAA, 16'hAAAA, 16'hAAAA));
        push_sample(mk(16'h0000, 16'h0000, 16'h4000, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        drain();

        // zero weights pass the input through; largest positive bias
        img[igr_pkg::REG_ACCEL_ALPHA]    = 32'hDEAD_0000;
        img[igr_pkg::REG_GYRO_LP_WEIGHT] = 32'hBEEF_0000;
        img[igr_pkg::REG_GRAVITY_ALPHA]  = 32'h1234_0000;
        img[igr_pkg::REG_GYRO_BIAS_X]    = 32'hA57F_FFFF;
        img[igr_pkg::REG_GYRO_BIAS_Y]    = 32'h5A7F_FFFF;
        img[igr_pkg::REG_GYRO_BIAS_Z]    = 32'hFF7F_FFFF;
        img[NUM_REGS]                    = $urandom;
        img[NUM_REGS+1]                  = $urandom;
        load_config(img);
        push_sample(mk(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000));
        push_sample(mk(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF));
        push_sample(mk(16'h0001, 16'hFFFF, 16'h4000, 16'h0000, 16'h0000, 16'h0000));
        push_sample(mk(random_axis(), random_axis(), random_axis(),
                       random_axis(), random_axis(), random_axis()));
        drain();

        // largest negative bias
        img[igr_pkg::REG_GYRO_BIAS_X] = 32'h5A80_0000;
        img[igr_pkg::REG_GYRO_BIAS_Y] = 32'h0080_0000;
        img[igr_pkg::REG_GYRO_BIAS_Z] = 32'hFF80_0000;
        img[NUM_REGS]                 = $urandom;
        img[NUM_REGS+1]               = $urandom;
        load_config(img);
        push_sample(mk(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF));
        push_sample(mk(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000));
        push_sample(mk(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        drain();

        // heaviest weights hold the previous value almost unchanged
        img[igr_pkg::REG_ACCEL_ALPHA]    = 32'h0000_FFFF;
        img[igr_pkg::REG_GYRO_LP_WEIGHT] = 32'hFFFF_FFFF;
        img[igr_pkg::REG_GRAVITY_ALPHA]  = 32'h8000_FFFF;
        img[igr_pkg::REG_GYRO_BIAS_X]    = 32'h0000_0000;
        img[igr_pkg::REG_GYRO_BIAS_Y]    = 32'h00FF_FFFF;
        img[igr_pkg::REG_GYRO_BIAS_Z]    = 32'h0000_0001;
        load_config(img);
        push_sample(mk(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
        push_sample(mk(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
        push_sample(mk(16'h7FFF, 16'h8000, 16'h0000, 16'h8000, 16'h7FFF, 16'h0000));
        push_sample(mk(16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0000, 16'h0000));
        drain();

        for (int p = 0; p < RAND_PHASES; p++) begin
            for (int k = 0; k < 3; k++) begin
                case ($urandom_range(5))
                    0: alpha = 16'h0000;
                    1: alpha = 16'hFFFF;
                    default: alpha = 16'($urandom);
                endcase
                img[igr_pkg::REG_ACCEL_ALPHA + k] = {16'($urandom), alpha};
                case ($urandom_range(5))
                    0: bias = 24'h7FFFFF;
                    1: bias = 24'h800000;
                    default: bias = 24'($urandom);
                endcase
                img[igr_pkg::REG_GYRO_BIAS_X + k] = {8'($urandom), bias};
            end
            img[NUM_REGS]   = $urandom;
            img[NUM_REGS+1] = $urandom;
            load_config(img);
            still = (p % 2 == 1);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                no_idle = (p == 0 && n < 200);
                if (p == 0 && n == 60)
                    hold_requests++;
                if (still && $urandom_range(9) != 0) begin
                    s = mk(16'($urandom_range(512) - 256), 16'($urandom_range(512) - 256),
                           16'(16384 + $urandom_range(512) - 256),
                           16'($urandom_range(128) - 64), 16'($urandom_range(128) - 64),
                           16'($urandom_range(128) - 64));
                end else begin
                    s = mk(random_axis(), random_axis(), random_axis(),
                           random_axis(), random_axis(), random_axis());
                end
                push_sample(s);
            end
            no_idle = 1'b0;
            drain();
        end

        if (tracker.mismatches == 0 && tracker.pending_motion.size() == 0)
            $display("imu_gravity_removal_filter test passed");
        else
            $display("imu_gravity_removal_filter test failed");
        $finish;
    end

endmodule
